// File: rtl/core/qbft_pkg.sv
// ----------------------------------------------------------------------------
// qbft_pkg
// Widths, types and the rotation matrix entry function for the quaternion
// body-frame transform core.
// ----------------------------------------------------------------------------
`default_nettype none

package qbft_pkg;

    // position and quaternion word widths
    localparam int POS_WIDTH  = 32;
    localparam int QUAT_WIDTH = 16;
    localparam int QFRAC      = QUAT_WIDTH - 2;

    // quaternion product, entry before and after rounding
    localparam int PROD_W    = 2 * QUAT_WIDTH;
    localparam int ENT_PRE_W = 2 * QUAT_WIDTH + 3;
    localparam int ENT_W     = QUAT_WIDTH + 4;

    // position difference, entry times difference, three-term sum
    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int MUL_W  = ENT_W + DIFF_W;
    localparam int ACC_W  = MUL_W + 2;
    localparam int RND_W  = ACC_W - QFRAC;

    // quaternion product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_ZW = 4;
    localparam int P_XZ = 5;
    localparam int P_YW = 6;
    localparam int P_YZ = 7;
    localparam int P_XW = 8;
    localparam int NUM_PROD = 9;

    localparam int NUM_ENT = 9;
    localparam int NUM_AXIS = 3;

    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [ENT_PRE_W-1:0] ent_pre_t;
    typedef logic signed [ENT_W-1:0]     ent_t;
    typedef logic signed [DIFF_W-1:0]    diff_t;
    typedef logic signed [MUL_W-1:0]     mul_t;
    typedef logic signed [ACC_W-1:0]     acc_t;
    typedef logic signed [RND_W-1:0]     rnd_t;

    localparam ent_pre_t ENT_ONE  = ENT_PRE_W'(1) << (2 * QFRAC);
    localparam ent_pre_t ENT_HALF = ENT_PRE_W'(1) << (QFRAC - 1);
    localparam acc_t     ACC_HALF = ACC_W'(1) << (QFRAC - 1);

    // Diagonal entries are 1 - 2(p1 + p2), the others 2(p1 +/- p2);
    // round half up back to QFRAC fraction bits.
    function automatic ent_t mat_entry(input logic diag, input prod_t p1,
                                       input prod_t p2, input logic sub);
        ent_pre_t a;
        ent_pre_t b;
        ent_pre_t v;
        begin
            a = {{(ENT_PRE_W-PROD_W){p1[PROD_W-1]}}, p1};
            b = {{(ENT_PRE_W-PROD_W){p2[PROD_W-1]}}, p2};
            if (sub)
            begin
                v = a - b;
            end
            else
            begin
                v = a + b;
            end
            v = v + v;
            if (diag)
            begin
                v = ENT_ONE - v;
            end
            v = v + ENT_HALF;
            return v[QFRAC+ENT_W-1:QFRAC];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/quaternion_body_frame_transform_core.sv
// ----------------------------------------------------------------------------
// quaternion_body_frame_transform_core
// Rotates one foot position into the body frame of a quaternion pose.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one transaction per foot:
//   leg tag, body position, orientation quaternion and foot position.
//   Output channel (out_valid / out_ready) returns the leg tag, the foot
//   position in the body frame (saturated) and an overflow flag.
//   From input to out_valid the stages are, in order: quaternion products
//   and position difference, matrix entries, nine entry-by-difference
//   multiplies, then sum, round and saturate into the output register.
//   Throughput is one transaction per cycle unless stalled; the multiply
//   stage does one 20 by 33 bit product per matrix entry per cycle. Reset
//   empties the pipeline: all stage valid bits clear, out_valid drops and
//   in_ready rises. When the receiver stalls, each stage holds its data
//   while the stage after it is full and stalled; bubbles still close up,
//   so in_ready only falls once every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_body_frame_transform_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            leg_tag,
    input  wire logic signed [qbft_pkg::POS_WIDTH-1:0]  body_x,
    input  wire logic signed [qbft_pkg::POS_WIDTH-1:0]  body_y,
    input  wire logic signed [qbft_pkg::POS_WIDTH-1:0]  body_z,
    input  wire logic signed [qbft_pkg::QUAT_WIDTH-1:0] quat_x,
    input  wire logic signed [qbft_pkg::QUAT_WIDTH-1:0] quat_y,
    input  wire logic signed [qbft_pkg::QUAT_WIDTH-1:0] quat_z,
    input  wire logic signed [qbft_pkg::QUAT_WIDTH-1:0] quat_w,
    input  wire logic signed [qbft_pkg::POS_WIDTH-1:0]  foot_x,
    input  wire logic signed [qbft_pkg::POS_WIDTH-1:0]  foot_y,
    input  wire logic signed [qbft_pkg::POS_WIDTH-1:0]  foot_z,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [1:0]                                 leg_out,
    output logic signed [qbft_pkg::POS_WIDTH-1:0]       rel_x,
    output logic signed [qbft_pkg::POS_WIDTH-1:0]       rel_y,
    output logic signed [qbft_pkg::POS_WIDTH-1:0]       rel_z,
    output logic                                       overflow
);

    localparam int P = qbft_pkg::POS_WIDTH;

    // Stage enables: a stage loads when it is empty or its data moves on.
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // Stage 1: quaternion products and foot minus body.
    logic                  v1_reg, v1_next;
    logic [1:0]            leg1_reg, leg1_next;
    qbft_pkg::prod_t       prod_reg [qbft_pkg::NUM_PROD];
    qbft_pkg::prod_t       prod_next [qbft_pkg::NUM_PROD];
    qbft_pkg::diff_t       d1_reg [qbft_pkg::NUM_AXIS];
    qbft_pkg::diff_t       d1_next [qbft_pkg::NUM_AXIS];

    // Stage 2: rotation matrix entries, row major.
    logic                  v2_reg, v2_next;
    logic [1:0]            leg2_reg, leg2_next;
    qbft_pkg::ent_t        ent_reg [qbft_pkg::NUM_ENT];
    qbft_pkg::ent_t        ent_next [qbft_pkg::NUM_ENT];
    qbft_pkg::diff_t       d2_reg [qbft_pkg::NUM_AXIS];

    // Stage 3: products, slot [axis*3 + k] = R[k][axis] * d[k].
    logic                  v3_reg, v3_next;
    logic [1:0]            leg3_reg, leg3_next;
    qbft_pkg::mul_t        mul_reg [qbft_pkg::NUM_ENT];
    qbft_pkg::mul_t        mul_next [qbft_pkg::NUM_ENT];

    // Stage 4: output register.
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            leg_out_reg;
    logic signed [P-1:0]   rel_reg [qbft_pkg::NUM_AXIS];
    logic signed [P-1:0]   rel_next [qbft_pkg::NUM_AXIS];
    logic                  overflow_reg, overflow_next;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign en4 = !out_valid_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ready = en1;

    assign v1_next        = en1 ? in_valid : v1_reg;
    assign v2_next        = en2 ? v1_reg   : v2_reg;
    assign v3_next        = en3 ? v2_reg   : v3_reg;
    assign out_valid_next = en4 ? v3_reg   : out_valid_reg;

    assign leg1_next = leg_tag;
    assign leg2_next = leg1_reg;
    assign leg3_next = leg2_reg;

    // ------------------------------------------------------------------
    // Stage 1 logic: 16 by 16 products and exact position difference
    // ------------------------------------------------------------------
    always_comb
    begin
        prod_next[qbft_pkg::P_XX] = quat_x * quat_x;
        prod_next[qbft_pkg::P_YY] = quat_y * quat_y;
        prod_next[qbft_pkg::P_ZZ] = quat_z * quat_z;
        prod_next[qbft_pkg::P_XY] = quat_x * quat_y;
        prod_next[qbft_pkg::P_ZW] = quat_z * quat_w;
        prod_next[qbft_pkg::P_XZ] = quat_x * quat_z;
        prod_next[qbft_pkg::P_YW] = quat_y * quat_w;
        prod_next[qbft_pkg::P_YZ] = quat_y * quat_z;
        prod_next[qbft_pkg::P_XW] = quat_x * quat_w;

        d1_next[0] = $signed({foot_x[P-1], foot_x}) - $signed({body_x[P-1], body_x});
        d1_next[1] = $signed({foot_y[P-1], foot_y}) - $signed({body_y[P-1], body_y});
        d1_next[2] = $signed({foot_z[P-1], foot_z}) - $signed({body_z[P-1], body_z});
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: matrix entries from the products
    // ------------------------------------------------------------------
    always_comb
    begin
        ent_next[0] = qbft_pkg::mat_entry(1'b1, prod_reg[qbft_pkg::P_YY],
                                          prod_reg[qbft_pkg::P_ZZ], 1'b0);
        ent_next[1] = qbft_pkg::mat_entry(1'b0, prod_reg[qbft_pkg::P_XY],
                                          prod_reg[qbft_pkg::P_ZW], 1'b1);
        ent_next[2] = qbft_pkg::mat_entry(1'b0, prod_reg[qbft_pkg::P_XZ],
                                          prod_reg[qbft_pkg::P_YW], 1'b0);
        ent_next[3] = qbft_pkg::mat_entry(1'b0, prod_reg[qbft_pkg::P_XY],
                                          prod_reg[qbft_pkg::P_ZW], 1'b0);
        ent_next[4] = qbft_pkg::mat_entry(1'b1, prod_reg[qbft_pkg::P_XX],
                                          prod_reg[qbft_pkg::P_ZZ], 1'b0);
        ent_next[5] = qbft_pkg::mat_entry(1'b0, prod_reg[qbft_pkg::P_YZ],
                                          prod_reg[qbft_pkg::P_XW], 1'b1);
        ent_next[6] = qbft_pkg::mat_entry(1'b0, prod_reg[qbft_pkg::P_XZ],
                                          prod_reg[qbft_pkg::P_YW], 1'b1);
        ent_next[7] = qbft_pkg::mat_entry(1'b0, prod_reg[qbft_pkg::P_YZ],
                                          prod_reg[qbft_pkg::P_XW], 1'b0);
        ent_next[8] = qbft_pkg::mat_entry(1'b1, prod_reg[qbft_pkg::P_XX],
                                          prod_reg[qbft_pkg::P_YY], 1'b0);
    end

    // ------------------------------------------------------------------
    // Stage 3 logic: transposed matrix times difference, one product per
    // entry; column 'axis' of R feeds result 'axis'
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int axis = 0; axis < qbft_pkg::NUM_AXIS; axis++)
        begin
            for (int k = 0; k < qbft_pkg::NUM_AXIS; k++)
            begin
                mul_next[axis*3 + k] = ent_reg[k*3 + axis] * d2_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4 logic: sum, round half up, saturate
    // ------------------------------------------------------------------
    always_comb
    begin
        qbft_pkg::acc_t        acc;
        qbft_pkg::rnd_t        rnd;
        logic [qbft_pkg::RND_W-P:0] top;
        overflow_next = 1'b0;
        for (int axis = 0; axis < qbft_pkg::NUM_AXIS; axis++)
        begin
            acc = mul_reg[axis*3] + mul_reg[axis*3 + 1] + mul_reg[axis*3 + 2]
                + qbft_pkg::ACC_HALF;
            rnd = acc[qbft_pkg::ACC_W-1:qbft_pkg::QFRAC];
            top = rnd[qbft_pkg::RND_W-1:P-1];
            if ((&top) || !(|top))
            begin
                rel_next[axis] = rnd[P-1:0];
            end
            else
            begin
                // clamp towards the sign of the sum
                overflow_next  = 1'b1;
                rel_next[axis] = rnd[qbft_pkg::RND_W-1] ? {1'b1, {(P-1){1'b0}}}
                                                        : {1'b0, {(P-1){1'b1}}};
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load on stage enable, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            leg1_reg <= leg1_next;
            prod_reg <= prod_next;
            d1_reg   <= d1_next;
        end
        if (en2)
        begin
            leg2_reg <= leg2_next;
            ent_reg  <= ent_next;
            d2_reg   <= d1_reg;
        end
        if (en3)
        begin
            leg3_reg <= leg3_next;
            mul_reg  <= mul_next;
        end
        if (en4)
        begin
            leg_out_reg  <= leg3_reg;
            rel_reg      <= rel_next;
            overflow_reg <= overflow_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign leg_out   = leg_out_reg;
    assign rel_x     = rel_reg[0];
    assign rel_y     = rel_reg[1];
    assign rel_z     = rel_reg[2];
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire
